// File: rtl/lsic_pkg.sv
// ----------------------------------------------------------------------------
// Lattice site index converter package
// Shared widths, codes, word types and the radix division step.
// ----------------------------------------------------------------------------
package lsic_pkg;

	localparam int SITE_W          = 20;
	localparam int CRD_W           = 16;
	localparam int LEN_W           = 7;
	localparam int DIG_W           = 6;
	localparam int SUB_W           = 2;
	localparam int DIMS_W          = 2;
	localparam int NQ              = 4;
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = 2;
	localparam int QCNT_W          = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 7;
	localparam int MAX_LENGTH      = 64;
	localparam int MAX_SUBLATTICES = 3;
	localparam int STEPS           = 4;
	localparam int DIV_STAGES      = SITE_W / STEPS;
	localparam int LAST_DIV_STAGE  = NQ * DIV_STAGES;
	localparam int NSTAGE          = LAST_DIV_STAGE + 1;

	typedef logic [1:0] qty_t;
	localparam qty_t Q_X   = 2'd0;
	localparam qty_t Q_Y   = 2'd1;
	localparam qty_t Q_Z   = 2'd2;
	localparam qty_t Q_SUB = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUBLAT = 3'd4;

	typedef struct packed {
		logic [DIMS_W-1:0]         dims;
		logic [2:0][LEN_W-1:0]     len;
		logic [SUB_W-1:0]          sublat;
	} cfg_t;

	typedef struct packed {
		logic                      kind;
		logic [NQ-1:0][CRD_W-1:0]  coord;
		logic [SITE_W-1:0]         site;
		logic [NQ-1:0][LEN_W-1:0]  qbase;
		logic [NQ-1:0][LEN_W-1:0]  base;
		qty_t [NQ-1:0]             which;
	} front_word_t;

	typedef struct packed {
		logic [SITE_W-1:0]         site_out;
		logic [2:0][DIG_W-1:0]     crd;
		logic [SUB_W-1:0]          sub;
		logic                      err;
	} result_t;

	typedef struct packed {
		logic                      kind;
		logic [NQ-1:0][LEN_W-1:0]  qbase;
		logic [NQ-1:0][LEN_W-1:0]  base;
		qty_t [NQ-1:0]             which;
		logic [NQ-1:0]             neg;
		logic [NQ-1:0][DIG_W-1:0]  rem0;
		logic [NQ-1:0][SITE_W-1:0] dq0;
		logic [DIG_W-1:0]          rem1;
		logic [SITE_W-1:0]         dq1;
		logic [NQ-1:0][DIG_W-1:0]  dig;
		logic [NQ-1:0][DIG_W-1:0]  v;
		logic [SITE_W-1:0]         acc;
		result_t                   res;
	} item_t;

	typedef struct packed {
		logic [DIG_W-1:0]  rem;
		logic [SITE_W-1:0] dq;
	} div_t;

	// One restoring division step: the dividend shifts out at the top while
	// quotient bits shift in at the bottom.
	function automatic div_t div_step(div_t x, logic [LEN_W-1:0] d);
		div_t             y;
		logic [LEN_W-1:0] t;
		logic [LEN_W-1:0] diff;
		logic             ge;
		t    = {x.rem, x.dq[SITE_W-1]};
		ge   = (t >= d);
		diff = t - d;
		y.rem = ge ? diff[DIG_W-1:0] : t[DIG_W-1:0];
		y.dq  = {x.dq[SITE_W-2:0], ge};
		return y;
	endfunction

endpackage

// File: rtl/lsic_front.sv
// ----------------------------------------------------------------------------
// Lattice site index converter front end
// Accepts words, derives the digit plan from the configuration and feeds
// the queue.
// ----------------------------------------------------------------------------
module lsic_front import lsic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [CRD_W-1:0]  coord_x,
	input  logic [CRD_W-1:0]  coord_y,
	input  logic [CRD_W-1:0]  coord_z,
	input  logic [CRD_W-1:0]  sublattice,
	input  logic [SITE_W-1:0] site_index,
	input  logic              q_full,
	output logic              q_push,
	output front_word_t       q_word
);

	function automatic logic [LEN_W-1:0] len_eff(logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (v > LEN_W'(MAX_LENGTH)) begin
			r = LEN_W'(MAX_LENGTH);
		end
		return r;
	endfunction

	front_word_t          word_s1;
	logic                 vld_s1;
	front_word_t          plan;
	logic [DIMS_W-1:0]    dims;
	logic [SUB_W-1:0]     ns;
	logic                 accept;
	logic                 spec_ok;
	qty_t                 spec;

	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = vld_s1 && !q_full;
	assign q_word   = word_s1;

	always_comb begin
		dims = (cfg.dims == '0) ? DIMS_W'(1) : cfg.dims;
		ns   = (cfg.sublat == '0) ? SUB_W'(1) : cfg.sublat;
		if (ns > SUB_W'(MAX_SUBLATTICES)) begin
			ns = SUB_W'(MAX_SUBLATTICES);
		end
		plan.kind  = kind;
		plan.coord = {sublattice, coord_z, coord_y, coord_x};
		plan.site  = site_index;
		for (int q = 0; q < 3; q++) begin
			plan.qbase[q] = (DIMS_W'(q) < dims) ? len_eff(cfg.len[q]) : LEN_W'(1);
		end
		plan.qbase[Q_SUB] = LEN_W'(ns);
		spec_ok = 1'b0;
		spec    = Q_X;
		if (ns[0]) begin
			for (int q = 2; q >= 0; q--) begin
				if (!plan.qbase[q][0]) begin
					spec_ok = 1'b1;
					spec    = qty_t'(q);
				end
			end
		end
		if (!spec_ok) begin
			plan.which = {Q_Z, Q_Y, Q_X, Q_SUB};
		end else begin
			unique case (spec)
				Q_X:     plan.which = {Q_SUB, Q_Z, Q_Y, Q_X};
				Q_Y:     plan.which = {Q_SUB, Q_Z, Q_X, Q_Y};
				default: plan.which = {Q_SUB, Q_Y, Q_X, Q_Z};
			endcase
		end
		for (int j = 0; j < NQ; j++) begin
			plan.base[j] = plan.qbase[plan.which[j]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= plan;
		end
	end

endmodule

// File: rtl/lsic_queue.sv
// ----------------------------------------------------------------------------
// Lattice site index converter queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lsic_queue import lsic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  front_word_t push_word,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output front_word_t head
);

	front_word_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// File: rtl/lsic_back.sv
// ----------------------------------------------------------------------------
// Lattice site index converter back end
// Pipelined radix division and mixed-radix accumulation, one word per cycle while not stalled.
// ----------------------------------------------------------------------------
module lsic_back import lsic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  front_word_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     res
);

	function automatic item_t init_item(front_word_t w);
		item_t            y;
		logic [CRD_W-1:0] mag;
		y = '0;
		y.kind  = w.kind;
		y.qbase = w.qbase;
		y.base  = w.base;
		y.which = w.which;
		y.dq1   = w.site;
		for (int q = 0; q < NQ; q++) begin
			y.neg[q] = w.coord[q][CRD_W-1];
			mag      = y.neg[q] ? ~w.coord[q] : w.coord[q];
			y.dq0[q] = SITE_W'(mag);
		end
		return y;
	endfunction

	function automatic item_t stage_fn(item_t x, int k, int div, int cap_idx, bit cap);
		item_t                    y;
		div_t                     d;
		logic [LEN_W-1:0]         top;
		logic [SITE_W+LEN_W-1:0]  prod;
		logic [NQ-1:0][DIG_W-1:0] val;
		y = x;
		if (cap) begin
			y.dig[cap_idx[1:0]] = y.rem1;
			y.rem1              = '0;
		end
		if (k < LAST_DIV_STAGE) begin
			d.rem = y.rem1;
			d.dq  = y.dq1;
			for (int s = 0; s < STEPS; s++) begin
				d = div_step(d, y.base[div[1:0]]);
			end
			y.rem1 = d.rem;
			y.dq1  = d.dq;
		end
		if (k < DIV_STAGES) begin
			for (int q = 0; q < NQ; q++) begin
				d.rem = y.rem0[q];
				d.dq  = y.dq0[q];
				for (int s = 0; s < STEPS; s++) begin
					d = div_step(d, y.qbase[q]);
				end
				y.rem0[q] = d.rem;
				y.dq0[q]  = d.dq;
			end
		end
		if (k == DIV_STAGES) begin
			for (int q = 0; q < NQ; q++) begin
				top     = y.qbase[q] - LEN_W'(1) - LEN_W'(y.rem0[q]);
				y.v[q]  = y.neg[q] ? top[DIG_W-1:0] : y.rem0[q];
			end
		end
		if (k == DIV_STAGES + 1) begin
			prod  = (SITE_W + LEN_W)'(y.v[y.which[3]]) * (SITE_W + LEN_W)'(y.base[2]);
			y.acc = prod[SITE_W-1:0] + SITE_W'(y.v[y.which[2]]);
		end
		if (k == DIV_STAGES + 2) begin
			prod  = (SITE_W + LEN_W)'(y.acc) * (SITE_W + LEN_W)'(y.base[1]);
			y.acc = prod[SITE_W-1:0] + SITE_W'(y.v[y.which[1]]);
		end
		if (k == DIV_STAGES + 3) begin
			prod  = (SITE_W + LEN_W)'(y.acc) * (SITE_W + LEN_W)'(y.base[0]);
			y.acc = prod[SITE_W-1:0] + SITE_W'(y.v[y.which[0]]);
		end
		if (k == LAST_DIV_STAGE) begin
			y.res = '0;
			if (!y.kind) begin
				y.res.site_out = y.acc;
				val            = y.v;
			end else begin
				y.res.err = (y.dq1 != '0);
				val       = '0;
				if (!y.res.err) begin
					for (int j = 0; j < NQ; j++) begin
						val[y.which[j]] = y.dig[j];
					end
				end
			end
			for (int q = 0; q < 3; q++) begin
				y.res.crd[q] = val[q];
			end
			y.res.sub = val[Q_SUB][SUB_W-1:0];
		end
		return y;
	endfunction

	item_t             pipe_q [NSTAGE];
	logic [NSTAGE-1:0] vld_q;
	logic              adv;

	assign adv       = !(vld_q[NSTAGE-1] && out_stall);
	assign q_pop     = adv && !q_empty;
	assign out_valid = vld_q[NSTAGE-1];
	assign res       = pipe_q[NSTAGE-1].res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTAGE-2:0], !q_empty};
		end
	end

	for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
		localparam int DIV     = (k < LAST_DIV_STAGE) ? k / DIV_STAGES : NQ - 1;
		localparam int CAP_IDX = (k >= DIV_STAGES) ? k / DIV_STAGES - 1 : 0;
		localparam bit CAP     = (k > 0) && (k % DIV_STAGES == 0);
		item_t nxt;
		if (k == 0) begin : g_first
			always_comb begin
				nxt = stage_fn(init_item(q_head), k, DIV, CAP_IDX, CAP);
			end
		end else begin : g_next
			always_comb begin
				nxt = stage_fn(pipe_q[k-1], k, DIV, CAP_IDX, CAP);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_q[k] <= nxt;
			end
		end
	end

endmodule

// File: rtl/lattice_site_index_converter_core.sv
// ----------------------------------------------------------------------------
// Lattice site index converter core
// Converts periodic lattice coordinates to a linear site index and back.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    kind, coord_x/y/z, sublattice, site_index
//   out      out_valid / out_stall  site_out, coord_x/y/z_out, sublattice_out,
//                                   range_error
//   cfg      cfg_wr_en              cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; each accepted word
// passes through the front register into the queue and then through the
// back end, which takes four division steps per division stage.
// Reset clears the valid bits and the queue and loads the configuration
// defaults. An output stall freezes the back end; the queue of four words
// keeps the input side accepting until it fills.
// ----------------------------------------------------------------------------
module lattice_site_index_converter_core import lsic_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [CRD_W-1:0]      coord_x,
	input  logic [CRD_W-1:0]      coord_y,
	input  logic [CRD_W-1:0]      coord_z,
	input  logic [CRD_W-1:0]      sublattice,
	input  logic [SITE_W-1:0]     site_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SITE_W-1:0]     site_out,
	output logic [DIG_W-1:0]      coord_x_out,
	output logic [DIG_W-1:0]      coord_y_out,
	output logic [DIG_W-1:0]      coord_z_out,
	output logic [SUB_W-1:0]      sublattice_out,
	output logic                  range_error
);

	cfg_t        cfg_q;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	front_word_t q_word;
	front_word_t q_head;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims   <= DIMS_W'(1);
			cfg_q.len[0] <= LEN_W'(1);
			cfg_q.len[1] <= LEN_W'(1);
			cfg_q.len[2] <= LEN_W'(1);
			cfg_q.sublat <= SUB_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DIMS:   cfg_q.dims   <= cfg_data[DIMS_W-1:0];
				REG_LEN_X:  cfg_q.len[0] <= cfg_data[LEN_W-1:0];
				REG_LEN_Y:  cfg_q.len[1] <= cfg_data[LEN_W-1:0];
				REG_LEN_Z:  cfg_q.len[2] <= cfg_data[LEN_W-1:0];
				REG_SUBLAT: cfg_q.sublat <= cfg_data[SUB_W-1:0];
				default: ;
			endcase
		end
	end

	lsic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.sublattice (sublattice),
		.site_index (site_index),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_word     (q_word)
	);

	lsic_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_word),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	lsic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign site_out       = res.site_out;
	assign coord_x_out    = res.crd[0];
	assign coord_y_out    = res.crd[1];
	assign coord_z_out    = res.crd[2];
	assign sublattice_out = res.sub;
	assign range_error    = res.err;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lattice site index converter testbench
// Drives coordinate and site index words through several lattice settings,
// predicts every result and compares it field by field as it leaves.
// ----------------------------------------------------------------------------
module tb_top;
	import lsic_pkg::*;

	typedef struct {
		logic [SITE_W-1:0] site;
		logic [DIG_W-1:0]  cx;
		logic [DIG_W-1:0]  cy;
		logic [DIG_W-1:0]  cz;
		logic [SUB_W-1:0]  sub;
		logic              err;
	} site_result_t;

	class site_scoreboard;
		logic [1:0] dims_reg;
		logic [6:0] len_reg [3];
		logic [1:0] sub_reg;
		site_result_t expected_q [$];
		int fails;

		function new();
			dims_reg = 2'd1;
			len_reg = '{7'd1, 7'd1, 7'd1};
			sub_reg = 2'd1;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DIMS: begin
					dims_reg = val[1:0];
				end
				REG_LEN_X: begin
					len_reg[0] = val;
				end
				REG_LEN_Y: begin
					len_reg[1] = val;
				end
				REG_LEN_Z: begin
					len_reg[2] = val;
				end
				REG_SUBLAT: begin
					sub_reg = val[1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int eff_len(int d);
			if (len_reg[d] == 0) return 1;
			if (len_reg[d] > MAX_LENGTH) return MAX_LENGTH;
			return int'(len_reg[d]);
		endfunction

		function int lattice_total();
			int t;
			int nd;
			nd = (dims_reg == 0) ? 1 : int'(dims_reg);
			t = (sub_reg == 0) ? 1 : int'(sub_reg);
			for (int d = 0; d < nd; d++) t *= eff_len(d);
			return t;
		endfunction

		function void note_word(logic k, logic [CRD_W-1:0] crd [4], logic [SITE_W-1:0] s);
			int nd, ns, spec, n, v, r, total;
			int len [3];
			int qty [4];
			int base [4];
			int val [4];
			longint acc;
			site_result_t e;
			nd = (dims_reg == 0) ? 1 : int'(dims_reg);
			ns = (sub_reg == 0) ? 1 : int'(sub_reg);
			for (int d = 0; d < 3; d++) len[d] = eff_len(d);
			val = '{0, 0, 0, 0};
			spec = nd;
			if (ns % 2 == 1) begin
				for (int d = nd - 1; d >= 0; d--) if (len[d] % 2 == 0) spec = d;
			end
			n = 0;
			if (spec != nd) begin
				qty[n] = spec; base[n] = len[spec]; n++;
				for (int d = 0; d < nd; d++) if (d != spec) begin
					qty[n] = d; base[n] = len[d]; n++;
				end
				qty[n] = 3; base[n] = ns; n++;
			end else begin
				qty[n] = 3; base[n] = ns; n++;
				for (int d = 0; d < nd; d++) begin
					qty[n] = d; base[n] = len[d]; n++;
				end
			end
			e.site = '0;
			e.err = 1'b0;
			if (k == 0) begin
				for (int q = 0; q < 4; q++) begin
					if (q < nd || q == 3) begin
						v = int'(signed'(crd[q]));
						r = v % ((q == 3) ? ns : len[q]);
						if (r < 0) r += (q == 3) ? ns : len[q];
						val[q] = r;
					end
				end
				acc = 0;
				for (int i = n - 1; i >= 0; i--) acc = acc * base[i] + val[qty[i]];
				e.site = acc[SITE_W-1:0];
			end else begin
				total = lattice_total();
				acc = s;
				if (acc >= total) begin
					e.err = 1'b1;
				end else begin
					for (int i = 0; i < n; i++) begin
						val[qty[i]] = int'(acc % base[i]);
						acc = acc / base[i];
					end
				end
			end
			e.cx = DIG_W'(val[0]);
			e.cy = DIG_W'(val[1]);
			e.cz = DIG_W'(val[2]);
			e.sub = SUB_W'(val[3]);
			expected_q.insert(expected_q.size(), e);
		endfunction

		function void check_word(site_result_t a);
			site_result_t e;
			if (expected_q.size() == 0) begin
				$error("Result word arrived with none expected.");
				fails++;
				return;
			end
			e = expected_q.pop_front();
			if (a.site !== e.site) begin
				$error("site_out: expected %0d, got %0d", e.site, a.site); fails++;
			end
			if (a.cx !== e.cx) begin
				$error("coord_x_out: expected %0d, got %0d", e.cx, a.cx); fails++;
			end
			if (a.cy !== e.cy) begin
				$error("coord_y_out: expected %0d, got %0d", e.cy, a.cy); fails++;
			end
			if (a.cz !== e.cz) begin
				$error("coord_z_out: expected %0d, got %0d", e.cz, a.cz); fails++;
			end
			if (a.sub !== e.sub) begin
				$error("sublattice_out: expected %0d, got %0d", e.sub, a.sub); fails++;
			end
			if (a.err !== e.err) begin
				$error("range_error: expected %0d, got %0d", e.err, a.err); fails++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0]  cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;
	logic                  in_valid = 0;
	logic                  in_stall;
	logic                  kind = 0;
	logic [CRD_W-1:0]      coord_x = 0;
	logic [CRD_W-1:0]      coord_y = 0;
	logic [CRD_W-1:0]      coord_z = 0;
	logic [CRD_W-1:0]      sublattice = 0;
	logic [SITE_W-1:0]     site_index = 0;
	logic                  out_valid;
	logic                  out_stall = 0;
	logic [SITE_W-1:0]     site_out;
	logic [DIG_W-1:0]      coord_x_out;
	logic [DIG_W-1:0]      coord_y_out;
	logic [DIG_W-1:0]      coord_z_out;
	logic [SUB_W-1:0]      sublattice_out;
	logic                  range_error;

	site_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	lattice_site_index_converter_core dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		site_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.site = site_out;
			r.cx = coord_x_out;
			r.cy = coord_y_out;
			r.cz = coord_z_out;
			r.sub = sublattice_out;
			r.err = range_error;
			board.check_word(r);
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_word(logic k, logic [CRD_W-1:0] crd [4], logic [SITE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		coord_x <= crd[0];
		coord_y <= crd[1];
		coord_z <= crd[2];
		sublattice <= crd[3];
		site_index <= s;
		do @(posedge clk); while (in_stall);
		board.note_word(k, crd, s);
	endtask

	task automatic set_lattice(int dm, int lx, int ly, int lz, int ns);
		int vals [5];
		vals = '{dm, lx, ly, lz, ns};
		wait (board.expected_q.size() == 0);
		repeat (30) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
			board.set_reg(CFG_IDX_W'(i), CFG_DATA_W'(vals[i]));
		end
		cfg_wr_en <= 0;
	endtask

	task automatic run_phase(int count, int mode);
		logic [CRD_W-1:0] crd [4];
		logic [SITE_W-1:0] s;
		int total;
		int modes_send [4] = '{0, 45, 0, 17};
		int modes_recv [4] = '{0, 0, 45, 17};
		send_idle_pct = modes_send[mode];
		recv_stall_pct = modes_recv[mode];
		total = board.lattice_total();
		crd = '{16'h7fff, 16'h8000, 16'hffff, 16'h8000};
		send_word(0, crd, 0);
		crd = '{16'h8000, 16'h7fff, 16'h0000, 16'h7fff};
		send_word(0, crd, 0);
		crd = '{0, 16'hffff, 16'h7fff, 16'hffff};
		send_word(0, crd, 0);
		send_word(1, crd, 0);
		send_word(1, crd, SITE_W'(total - 1));
		send_word(1, crd, SITE_W'(total));
		send_word(1, crd, 20'hfffff);
		for (int i = 0; i < count; i++) begin
			for (int q = 0; q < 4; q++) begin
				if ($urandom_range(2) == 0) crd[q] = CRD_W'($urandom);
				else crd[q] = CRD_W'($urandom_range(260) - 130);
			end
			case ($urandom_range(9))
				0: s = SITE_W'($urandom);
				1: s = SITE_W'(total + $urandom_range(3));
				default: s = SITE_W'($urandom_range(total - 1));
			endcase
			send_word(1'($urandom_range(1)), crd, s);
		end
		in_valid <= 0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_phase(60, 0);
		set_lattice(3, 64, 64, 64, 3); run_phase(160, 1);
		set_lattice(0, 5, 7, 9, 2); run_phase(150, 2);
		set_lattice(2, 6, 3, 1, 1); run_phase(150, 3);
		set_lattice(3, 127, 0, 64, 0); run_phase(150, 0);
		set_lattice(1, 64, 1, 1, 3); run_phase(150, 1);
		set_lattice(3, 3, 5, 4, 3); run_phase(150, 2);
		set_lattice(2, 7, 9, 2, 2); run_phase(150, 3);
		set_lattice(3, 1, 1, 1, 1); run_phase(100, 0);
		set_lattice(3, 2, 2, 2, 3); run_phase(150, 1);
		set_lattice($urandom_range(3), $urandom_range(127), $urandom_range(127),
			$urandom_range(127), $urandom_range(3));
		run_phase(150, 2);
		wait (board.expected_q.size() == 0);
		repeat (40) @(posedge clk);
		if (board.fails == 0 && board.expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
